>>> rtl/heap_sort_engine_assert.svh
// Assertion macros used by the heap sort engine datapath.
`ifndef HEAP_SORT_ENGINE_ASSERT_SVH
`define HEAP_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hse_pkg.sv
// Shared constants, types and the compare function of the heap sort engine.
`timescale 1ns / 1ps

package hse_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int DATA_W       = 32;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // Sort order register codes.
  localparam logic ORDER_ASC  = 1'b0;
  localparam logic ORDER_DESC = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_BUILD_INIT,
    OP_BUILD_PICK,
    OP_HOLD_LD,
    OP_SIFT_L,
    OP_SIFT_R,
    OP_SIFT_C,
    OP_EXT_INIT,
    OP_EXT_ROOT,
    OP_EXT_TAIL,
    OP_EXT_SWAP,
    OP_OUT_INIT,
    OP_OUT_RD,
    OP_OUT_LD
  } hse_op_e;

  typedef struct packed {
    hse_op_e op;
  } hse_cmd_t;

  typedef struct packed {
    logic i_zero;     // loop index reached zero
    logic sift_end;   // left child lies outside the heap
    logic sift_stop;  // parent beats both children
    logic out_free;   // output register can take a result
    logic out_last;   // current read is the final result
  } hse_sts_t;

  // Child moves up unless it lies strictly on the wrong side of cur.
  function automatic logic child_wins(logic order, data_t child, data_t cur);
    logic res;
    if (order == ORDER_ASC) begin
      res = !(child < cur);
    end else begin
      res = !(cur < child);
    end
    return res;
  endfunction

endpackage

>>> rtl/heap_sort_engine.sv
// Top level of the heap sort engine: joins the controller and the datapath.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------------------
//   in      | input     | in_valid_i / in_stall_o  | value_i, last_item_i
//   out     | output    | out_valid_o / out_stall_i| sorted_value_o, last_result_o, overflow_o
//   cfg     | input     | cfg_we_i                 | cfg_wdata_i (sort order)
//
// Loading accepts one item per cycle. After the item marked last, the sort runs on the single
// read port of the heap memory: each sift level steps through SIFT_L, SIFT_R and SIFT_C, and
// each result through OUT_RD and OUT_LD. No item is taken until the final result loads.
// Reset clears the count, drop flag and sort order; the heap memory needs no clearing.
// A stalled output holds the result register and pauses the result sequence.
`timescale 1ns / 1ps

module heap_sort_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hse_pkg::data_t value_i,
  input  logic           last_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hse_pkg::data_t sorted_value_o,
  output logic           last_result_o,
  output logic           overflow_o
);
  import hse_pkg::*;

  hse_cmd_t cmd;
  hse_sts_t sts;

  hse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_item_i (last_item_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hse_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .value_i        (value_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .sorted_value_o (sorted_value_o),
    .last_result_o  (last_result_o),
    .overflow_o     (overflow_o)
  );

endmodule

>>> rtl/hse_ctrl.sv
// Controller state machine of the heap sort engine: sequences load, build, extract, output.
`timescale 1ns / 1ps

module hse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_item_i,
  output logic              in_stall_o,
  input  hse_pkg::hse_sts_t sts_i,
  output hse_pkg::hse_cmd_t cmd_o
);
  import hse_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD_INIT,
    ST_BUILD_PICK,
    ST_HOLD_LD,
    ST_SIFT_L,
    ST_SIFT_R,
    ST_SIFT_C,
    ST_EXT_ROOT,
    ST_EXT_TAIL,
    ST_EXT_SWAP,
    ST_OUT_RD,
    ST_OUT_LD
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        build_q, build_d;
  logic        stall_q;
  ctrl_state_e sift_ret;

  assign in_stall_o = stall_q;
  assign sift_ret   = build_q ? ST_BUILD_PICK : ST_EXT_ROOT;

  always_comb begin
    state_d    = state_q;
    build_d    = build_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (last_item_i) begin
            state_d = ST_BUILD_INIT;
          end
        end
      end
      ST_BUILD_INIT: begin
        cmd_o.op = OP_BUILD_INIT;
        build_d  = 1'b1;
        state_d  = ST_BUILD_PICK;
      end
      ST_BUILD_PICK: begin
        if (sts_i.i_zero) begin
          cmd_o.op = OP_EXT_INIT;
          build_d  = 1'b0;
          state_d  = ST_EXT_ROOT;
        end else begin
          cmd_o.op = OP_BUILD_PICK;
          state_d  = ST_HOLD_LD;
        end
      end
      ST_HOLD_LD: begin
        cmd_o.op = OP_HOLD_LD;
        state_d  = ST_SIFT_L;
      end
      ST_SIFT_L: begin
        cmd_o.op = OP_SIFT_L;
        state_d  = sts_i.sift_end ? sift_ret : ST_SIFT_R;
      end
      ST_SIFT_R: begin
        cmd_o.op = OP_SIFT_R;
        state_d  = ST_SIFT_C;
      end
      ST_SIFT_C: begin
        cmd_o.op = OP_SIFT_C;
        state_d  = sts_i.sift_stop ? sift_ret : ST_SIFT_L;
      end
      ST_EXT_ROOT: begin
        if (sts_i.i_zero) begin
          cmd_o.op = OP_OUT_INIT;
          state_d  = ST_OUT_RD;
        end else begin
          cmd_o.op = OP_EXT_ROOT;
          state_d  = ST_EXT_TAIL;
        end
      end
      ST_EXT_TAIL: begin
        cmd_o.op = OP_EXT_TAIL;
        state_d  = ST_EXT_SWAP;
      end
      ST_EXT_SWAP: begin
        cmd_o.op = OP_EXT_SWAP;
        state_d  = ST_SIFT_L;
      end
      ST_OUT_RD: begin
        cmd_o.op = OP_OUT_RD;
        state_d  = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        cmd_o.op = OP_OUT_LD;
        if (sts_i.out_free) begin
          state_d = sts_i.out_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      build_q <= 1'b0;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      build_q <= build_d;
      stall_q <= (state_d != ST_IDLE);
    end
  end

endmodule

>>> rtl/hse_datapath.sv
// Datapath of the heap sort engine: heap memory, sift registers and output register.
`timescale 1ns / 1ps
`include "heap_sort_engine_assert.svh"

module hse_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hse_pkg::hse_cmd_t cmd_i,
  output hse_pkg::hse_sts_t sts_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  hse_pkg::data_t    value_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output hse_pkg::data_t    sorted_value_o,
  output logic              last_result_o,
  output logic              overflow_o
);
  import hse_pkg::*;

  data_t mem [MAX_ELEMENTS];

  logic  order_q;
  cnt_t  cnt_q;
  logic  drop_q;
  cnt_t  n_q;
  cnt_t  i_q;
  addr_t pos_q;
  data_t hold_q;
  data_t bval_q;
  logic  bsel_q;
  data_t rdata_q;
  logic  out_valid_q;
  data_t out_value_q;
  logic  out_last_q;
  logic  out_ovf_q;

  cnt_t           lidx;
  logic [CNT_W:0] ridx;
  cnt_t           i_dec;
  logic           r_in;
  logic           lwin;
  logic           rwin;
  logic           full;
  logic           out_load;

  logic  rd_en;
  addr_t rd_addr;
  logic  wr_en;
  addr_t wr_addr;
  data_t wr_data;

  assign lidx  = {pos_q, 1'b1};
  assign ridx  = {1'b0, lidx} + {{CNT_W{1'b0}}, 1'b1};
  assign i_dec = i_q - {{(CNT_W-1){1'b0}}, 1'b1};
  assign r_in  = (ridx < {1'b0, n_q});
  assign full  = (cnt_q == cnt_t'(MAX_ELEMENTS));
  assign lwin  = child_wins(order_q, rdata_q, hold_q);
  assign rwin  = r_in && child_wins(order_q, rdata_q, bval_q);

  assign sts_o.i_zero    = (i_q == '0);
  assign sts_o.sift_end  = (lidx >= n_q);
  assign sts_o.sift_stop = !rwin && !bsel_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.out_last  = (i_q == cnt_q - {{(CNT_W-1){1'b0}}, 1'b1});

  assign out_load = (cmd_i.op == OP_OUT_LD) && sts_o.out_free;

  // Memory port selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = hold_q;
    case (cmd_i.op)
      OP_LOAD: begin
        wr_en   = !full;
        wr_addr = cnt_q[ADDR_W-1:0];
        wr_data = value_i;
      end
      OP_BUILD_PICK: begin
        rd_en   = 1'b1;
        rd_addr = i_dec[ADDR_W-1:0];
      end
      OP_SIFT_L: begin
        if (sts_o.sift_end) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = lidx[ADDR_W-1:0];
        end
      end
      OP_SIFT_R: begin
        rd_en   = r_in;
        rd_addr = ridx[ADDR_W-1:0];
      end
      OP_SIFT_C: begin
        wr_en = 1'b1;
        if (rwin) begin
          wr_data = rdata_q;
        end else if (bsel_q) begin
          wr_data = bval_q;
        end
      end
      OP_EXT_ROOT: begin
        rd_en = 1'b1;
      end
      OP_EXT_TAIL: begin
        rd_en   = 1'b1;
        rd_addr = i_dec[ADDR_W-1:0];
      end
      OP_EXT_SWAP: begin
        wr_en   = 1'b1;
        wr_addr = i_dec[ADDR_W-1:0];
        wr_data = bval_q;
      end
      OP_OUT_RD: begin
        rd_en   = 1'b1;
        rd_addr = i_q[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Sift and loop registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_BUILD_INIT: begin
        n_q <= cnt_q;
        i_q <= cnt_q >> 1;
      end
      OP_BUILD_PICK: begin
        pos_q <= i_dec[ADDR_W-1:0];
        i_q   <= i_dec;
      end
      OP_HOLD_LD: begin
        hold_q <= rdata_q;
      end
      OP_SIFT_R: begin
        bval_q <= lwin ? rdata_q : hold_q;
        bsel_q <= lwin;
      end
      OP_SIFT_C: begin
        if (rwin) begin
          pos_q <= ridx[ADDR_W-1:0];
        end else if (bsel_q) begin
          pos_q <= lidx[ADDR_W-1:0];
        end
      end
      OP_EXT_INIT: begin
        i_q <= cnt_q;
      end
      OP_EXT_TAIL: begin
        bval_q <= rdata_q;
      end
      OP_EXT_SWAP: begin
        hold_q <= rdata_q;
        n_q    <= i_dec;
        pos_q  <= '0;
        i_q    <= i_dec;
      end
      OP_OUT_INIT: begin
        i_q <= '0;
      end
      OP_OUT_LD: begin
        if (out_load) begin
          i_q <= i_q + {{(CNT_W-1){1'b0}}, 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers: order, fill count, drop flag, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= ORDER_ASC;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_LOAD) begin
        if (full) begin
          drop_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
        end
      end
      // Clear the run once its final result is loaded into the output register.
      if (out_load && sts_o.out_last) begin
        cnt_q  <= '0;
        drop_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= rdata_q;
      out_last_q  <= sts_o.out_last;
      out_ovf_q   <= drop_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign last_result_o  = out_last_q;
  assign overflow_o     = out_ovf_q;

  `HSE_ASSERT_NXT(a_full_load_drops, (cmd_i.op == OP_LOAD) && full, drop_q, "full load did not set drop flag")
  `HSE_ASSERT_NXT(a_last_clears_run, out_load && sts_o.out_last, (cnt_q == '0) && !drop_q, "run not cleared after final item")
  `HSE_ASSERT_NXT(a_sift_moves_down, (cmd_i.op == OP_SIFT_C) && !sts_o.sift_stop, pos_q > $past(pos_q), "sift position did not move down")
  `HSE_ASSERT_IMP(a_count_bounded, 1'b1, cnt_q <= cnt_t'(MAX_ELEMENTS), "element count beyond capacity")

endmodule

>>> tb/heap_sort_engine_tb.sv
// Self-checking testbench for the heap sort engine: random sets, both sort orders, overflow.
`timescale 1ns / 1ps

module heap_sort_engine_tb;
  import hse_pkg::*;

  localparam int SET_BUDGET  = 77;     // minimum items per random phase
  localparam int LONG_HOLD   = 300;    // cycles the result side holds off once
  localparam int SETTLE      = 8;      // idle cycles before a register write
  localparam int DRAIN       = 40;     // cycles after the last result
  localparam int QUIET_LIMIT = 20000;  // cycles with no transfer before giving up

  typedef struct {
    data_t value;
    logic  last;
    logic  ovf;
  } sorted_t;

  // Tracks the set being loaded and the sorted results it will produce.
  class heap_order_scoreboard;
    data_t   loaded[$];
    logic    dropped;
    logic    order;
    sorted_t awaited[$];
    int      errors;

    function new();
      dropped = 1'b0;
      order   = ORDER_ASC;
      errors  = 0;
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function bit goes_first(data_t a, data_t b);
      if (order == ORDER_ASC) begin
        return a < b;
      end
      return a > b;
    endfunction

    function void note_value(data_t v, logic last);
      data_t run[$];
      data_t key;
      int    i;
      int    j;
      if (loaded.size() < MAX_ELEMENTS) begin
        loaded.push_back(v);
      end else begin
        dropped = 1'b1;
      end
      if (!last) begin
        return;
      end
      run = loaded;
      for (i = 1; i < run.size(); i++) begin
        key = run[i];
        j   = i - 1;
        while (j >= 0 && goes_first(key, run[j])) begin
          run[j+1] = run[j];
          j--;
        end
        run[j+1] = key;
      end
      foreach (run[k]) begin
        awaited.push_back('{value: run[k], last: (k == run.size() - 1), ovf: dropped});
      end
      loaded.delete();
      dropped = 1'b0;
    endfunction

    function void check_sorted(data_t v, logic last, logic ovf);
      sorted_t e;
      if (awaited.size() == 0) begin
        note_error($sformatf("unexpected result: value %0d last %0b overflow %0b",
                             v, last, ovf));
        return;
      end
      e = awaited.pop_front();
      if (v !== e.value || last !== e.last || ovf !== e.ovf) begin
        note_error($sformatf({"result mismatch: expected value %0d last %0b overflow %0b,",
                              " got value %0d last %0b overflow %0b"},
                             e.value, e.last, e.ovf, v, last, ovf));
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void close();
      if (awaited.size() != 0) begin
        note_error($sformatf("%0d results never arrived", awaited.size()));
      end
    endfunction
  endclass

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  cfg_we_i    = 1'b0;
  logic  cfg_wdata_i = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_stall_o;
  data_t value_i     = '0;
  logic  last_item_i = 1'b0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  data_t sorted_value_o;
  logic  last_result_o;
  logic  overflow_o;

  heap_order_scoreboard order_sb = new();
  bit calm        = 1'b0;
  bit hold_armed  = 1'b0;
  int items_sent  = 0;

  heap_sort_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .last_item_i   (last_item_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sorted_value_o(sorted_value_o),
    .last_result_o (last_result_o),
    .overflow_o    (overflow_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic data_t rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      4: return data_t'($urandom_range(0, 16)) - 8;  // dense range, many equal keys
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return $urandom_range(65, 70);
    end else if (r == 1) begin
      return $urandom_range(40, 64);
    end
    return $urandom_range(1, 12);
  endfunction

  // Offer one item, with an occasional gap first, and wait until it is taken.
  task automatic send_item(input data_t v, input logic last);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    value_i     <= v;
    last_item_i <= last;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    order_sb.note_value(v, last);
    items_sent++;
  endtask

  task automatic send_list(input data_t vals[$]);
    foreach (vals[k]) begin
      send_item(vals[k], k == vals.size() - 1);
    end
  endtask

  task automatic send_random_set(input int n);
    for (int k = 0; k < n; k++) begin
      send_item(rand_value(), k == n - 1);
    end
  endtask

  // Drain every pending result, let the engine settle, then write the order.
  task automatic write_sort_order(input logic o);
    in_valid_i <= 1'b0;
    while (order_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_wdata_i <= o;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    order_sb.order = o;
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        order_sb.check_sorted(sorted_value_o, last_result_o, overflow_o);
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_armed && out_valid_o) begin
        hold_armed = 1'b0;
        stall_left = LONG_HOLD;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("heap_sort_engine_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    int   phase_start;
    int   first_size;
    logic phase_order;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extremes and equal keys under both orders, and a single-element set under descending order.
    write_sort_order(ORDER_DESC);
    send_list('{32'h7FFF_FFFF, 32'h8000_0000, 0, -1, 1, 5, 5, -5});
    send_list('{-3});
    write_sort_order(ORDER_ASC);
    send_list('{32'h7FFF_FFFF, 32'h8000_0000, 0, -1, 1, 5, 5, -5});
    send_list('{9, 9, 9});
    send_list('{32'h8000_0000, 32'h7FFF_FFFF});

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          phase_order = ORDER_DESC;
          first_size  = MAX_ELEMENTS + 1;  // last item lands on a full store
        end
        1: begin
          phase_order = ORDER_ASC;
          first_size  = MAX_ELEMENTS;      // exactly full, no drop
        end
        2: begin
          phase_order = ORDER_DESC;
          first_size  = MAX_ELEMENTS + 6;
        end
        default: begin
          phase_order = logic'($urandom_range(0, 1));
          first_size  = pick_size();
        end
      endcase
      write_sort_order(phase_order);
      calm = (phase == 3);
      // Hold results back on the full set while the next set waits at the input.
      hold_armed  = (phase == 1);
      phase_start = items_sent;
      send_random_set(first_size);
      while (items_sent - phase_start < SET_BUDGET) begin
        send_random_set(pick_size());
      end
    end

    in_valid_i <= 1'b0;
    while (order_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    order_sb.close();
    if (order_sb.errors == 0) begin
      $display("heap_sort_engine_tb: PASS");
    end else begin
      $display("heap_sort_engine_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/hse_pkg.sv
rtl/hse_ctrl.sv
rtl/hse_datapath.sv
rtl/heap_sort_engine.sv
tb/heap_sort_engine_tb.sv
